// ===== design/fccw_pkg.sv =====
// ----------------------------------------------------------------------------
// fccw_pkg
// Shared types and constants of the FAT12 cluster chain walker.
// ----------------------------------------------------------------------------
package fccw_pkg;

	// Default sizes of the table store and of the longest chain that is followed.
	localparam int TABLE_BYTES_DEF = 8192;
	localparam int MAX_CHAIN_DEF   = 64;

	// Field widths.
	localparam int ADDR_W    = 13;
	localparam int BYTE_W    = 8;
	localparam int CLUSTER_W = 12;
	localparam int SECTOR_W  = 20;
	localparam int STEP_W    = 7;
	localparam int DRS_W     = 16;
	localparam int SPC_W     = 8;
	localparam int STATUS_W  = 2;

	// Stream and configuration widths.
	localparam int S_TDATA_W = 40;
	localparam int M_TDATA_W = 32;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DAT_W = 16;

	// FAT12 constants.
	localparam logic [CLUSTER_W-1:0] CHAIN_END  = 12'hff8;
	localparam logic [CLUSTER_W-1:0] FIRST_DATA = 12'd2;

	// Input item kinds.
	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_WALK = 1'b1;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_DATA_START  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_SECT_PER_CL = 1'b1;

	// Result status codes.
	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 2'd0,
		ST_BELOW_TWO = 2'd1,
		ST_TOO_LONG  = 2'd2
	} status_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic start;      // load the start cluster, clear the step count
		logic store;      // write one table byte
		logic rd_lo;      // read the low byte of the entry
		logic rd_hi;      // read the high byte, keep the low byte
		logic emit_low;   // emit the result of a cluster below two
		logic emit_entry; // emit the result of an ordinary cluster
		logic advance;    // move to the next cluster of the chain
	} ctrl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic below_two;  // current cluster is 0 or 1
		logic chain_stop; // entry ends the chain or the chain is full
		logic out_free;   // output register can take a result this cycle
	} dp_stat_t;

endpackage

// ===== design/fccw_ctrl.sv =====
// ----------------------------------------------------------------------------
// fccw_ctrl
// State machine that sequences loads and chain walks.
// ----------------------------------------------------------------------------
module fccw_ctrl
	import fccw_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic       item_cmd,
	input  dp_stat_t   stat,
	output ctrl_cmd_t  cmd
);

	typedef enum logic [3:0] {
		S_IDLE     = 4'b0001,
		S_CHECK    = 4'b0010,
		S_FETCH_HI = 4'b0100,
		S_STEP     = 4'b1000
	} state_t;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		s_tready = 1'b0;
		case (state_q)
			S_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					if (item_cmd == CMD_WALK) begin
						cmd.start = 1'b1;
						state_d   = S_CHECK;
					end else begin
						cmd.store = 1'b1;
					end
				end
			end
			S_CHECK: begin
				if (stat.below_two) begin
					if (stat.out_free) begin
						cmd.emit_low = 1'b1;
						state_d      = S_IDLE;
					end
				end else begin
					cmd.rd_lo = 1'b1;
					state_d   = S_FETCH_HI;
				end
			end
			S_FETCH_HI: begin
				cmd.rd_hi = 1'b1;
				state_d   = S_STEP;
			end
			S_STEP: begin
				if (stat.out_free) begin
					cmd.emit_entry = 1'b1;
					if (stat.chain_stop) begin
						state_d = S_IDLE;
					end else begin
						cmd.advance = 1'b1;
						state_d     = S_CHECK;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// No new item is taken while a walk is using the table port.
	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !(cmd.rd_lo || cmd.rd_hi || cmd.emit_entry || cmd.emit_low))
		else $error("fccw_ctrl: ready raised during a walk");

endmodule

// ===== design/fccw_datapath.sv =====
// ----------------------------------------------------------------------------
// fccw_datapath
// Table store, chain registers, sector arithmetic and result register.
// ----------------------------------------------------------------------------
module fccw_datapath
	import fccw_pkg::*;
#(
	parameter int TABLE_BYTES = TABLE_BYTES_DEF,
	parameter int MAX_CHAIN   = MAX_CHAIN_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  ctrl_cmd_t            cmd,
	output dp_stat_t             stat,
	input  logic [ADDR_W-1:0]    table_addr,
	input  logic [BYTE_W-1:0]    table_byte,
	input  logic [CLUSTER_W-1:0] start_cluster,
	input  logic                 cfg_valid,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DAT_W-1:0] cfg_data,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [CLUSTER_W-1:0] out_cluster,
	output logic [SECTOR_W-1:0]  out_sector,
	output logic                 out_last,
	output status_t              out_status
);

	localparam int AW = $clog2(TABLE_BYTES);
	localparam logic [ADDR_W:0] TB_LIM = (ADDR_W+1)'(TABLE_BYTES);

	logic [BYTE_W-1:0]    mem [TABLE_BYTES];
	logic [BYTE_W-1:0]    rdata_q;
	logic                 oob_q;
	logic [BYTE_W-1:0]    lo_q;
	logic [DRS_W-1:0]     drs_q;
	logic [SPC_W-1:0]     spc_q;
	logic [CLUSTER_W-1:0] cur_q;
	logic [STEP_W-1:0]    step_q;
	logic                 valid_q;

	logic [ADDR_W-1:0]    idx;
	logic [ADDR_W-1:0]    rd_addr;
	logic                 rd_en;
	logic [BYTE_W-1:0]    hi_byte;
	logic [15:0]          pair;
	logic [CLUSTER_W-1:0] nxt;
	logic [SECTOR_W-1:0]  prod;
	logic [SECTOR_W-1:0]  sector;
	logic                 chain_full;

	// Byte offset of the entry: cluster * 3 / 2.
	assign idx     = ADDR_W'(cur_q) + ADDR_W'(cur_q >> 1);
	assign rd_addr = cmd.rd_hi ? (idx + ADDR_W'(1)) : idx;
	assign rd_en   = cmd.rd_lo || cmd.rd_hi;

	always_ff @(posedge clk) begin
		if (cmd.store && ({1'b0, table_addr} < TB_LIM)) begin
			mem[table_addr[AW-1:0]] <= table_byte;
		end
		if (rd_en) begin
			rdata_q <= mem[rd_addr[AW-1:0]];
			oob_q   <= !({1'b0, rd_addr} < TB_LIM);
		end
		if (cmd.rd_hi) begin
			lo_q <= oob_q ? '0 : rdata_q;
		end
	end

	assign hi_byte = oob_q ? '0 : rdata_q;
	assign pair    = {hi_byte, lo_q};
	assign nxt     = cur_q[0] ? pair[15:4] : pair[11:0];

	assign prod   = SECTOR_W'(cur_q - FIRST_DATA) * SECTOR_W'(spc_q);
	assign sector = SECTOR_W'(drs_q) + prod;

	assign chain_full = (step_q >= STEP_W'(MAX_CHAIN - 1));

	assign stat.below_two  = (cur_q < FIRST_DATA);
	assign stat.chain_stop = (nxt >= CHAIN_END) || chain_full;
	assign stat.out_free   = !valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drs_q   <= '0;
			spc_q   <= SPC_W'(1);
			cur_q   <= '0;
			step_q  <= '0;
			valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					REG_DATA_START:  drs_q <= cfg_data;
					REG_SECT_PER_CL: spc_q <= cfg_data[SPC_W-1:0];
					default: ;
				endcase
			end
			if (cmd.start) begin
				cur_q  <= start_cluster;
				step_q <= '0;
			end else begin
				if (cmd.advance) begin
					cur_q <= nxt;
				end
				if (cmd.emit_entry || cmd.emit_low) begin
					step_q <= step_q + STEP_W'(1);
				end
			end
			if (cmd.emit_entry || cmd.emit_low) begin
				valid_q <= 1'b1;
			end else if (m_tready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_low) begin
			out_cluster <= cur_q;
			out_sector  <= '0;
			out_last    <= 1'b1;
			out_status  <= ST_BELOW_TWO;
		end else if (cmd.emit_entry) begin
			out_cluster <= cur_q;
			out_sector  <= sector;
			out_last    <= stat.chain_stop;
			out_status  <= (nxt >= CHAIN_END) ? ST_OK :
			               (chain_full ? ST_TOO_LONG : ST_OK);
		end
	end

	assign m_tvalid = valid_q;

	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit_entry || cmd.emit_low) |-> stat.out_free)
		else $error("fccw_datapath: result overwrites one not yet taken");

	a_step_bound: assert property (@(posedge clk) disable iff (!arst_n)
		step_q <= STEP_W'(MAX_CHAIN))
		else $error("fccw_datapath: chain ran past its limit");

	a_store_alone: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.store |-> !rd_en)
		else $error("fccw_datapath: table write during a walk read");

	a_full_last: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit_entry && chain_full) |=> (m_tvalid && out_last))
		else $error("fccw_datapath: full chain result not marked last");

endmodule

// ===== design/fat12_cluster_chain_walker.sv =====
// ----------------------------------------------------------------------------
// fat12_cluster_chain_walker
// Follows a FAT12 cluster chain held in an internal table store.
// ----------------------------------------------------------------------------
// A load beat (tuser 0) writes one byte of the allocation table; addresses
// at or above TABLE_BYTES are dropped. A walk beat (tuser 1) gives a start
// cluster, and the block then emits one result beat per cluster of the
// chain, with the cluster number and its first sector. For each cluster the
// block reads the low and then the high byte of the packed 12-bit entry
// through the single table port, then assembles the entry and loads the
// result register, waiting there while the result side stalls. A cluster
// below two needs no table read. The next beat is taken once the walk's
// last result is in the output register. The final result of a walk
// carries tlast; its tuser status is 1 for a cluster below two (sector 0)
// and 2 when the chain is cut at MAX_CHAIN results. The table is not
// cleared at reset: load every entry a walk will touch before starting it.
// Configuration writes are always accepted and belong to idle periods of
// the stream.
module fat12_cluster_chain_walker
	import fccw_pkg::*;
#(
	parameter int TABLE_BYTES = TABLE_BYTES_DEF,
	parameter int MAX_CHAIN   = MAX_CHAIN_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// Item stream.
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [S_TDATA_W-1:0] s_tdata,  // table_addr[12:0], table_byte[20:13],
	                                       // start_cluster[32:21], zero fill
	input  logic                 s_tuser,  // cmd
	// Result stream.
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [M_TDATA_W-1:0] m_tdata,  // cluster[11:0], sector_addr[31:12]
	output logic                 m_tlast,  // last
	output logic [STATUS_W-1:0]  m_tuser,  // status
	// Register writes.
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DAT_W-1:0] cfg_data
);

	ctrl_cmd_t            cmd;
	dp_stat_t             stat;
	logic [CLUSTER_W-1:0] out_cluster;
	logic [SECTOR_W-1:0]  out_sector;
	status_t              out_status;

	// Register writes never stall.
	assign cfg_ready = 1'b1;

	fccw_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.item_cmd (s_tuser),
		.stat     (stat),
		.cmd      (cmd)
	);

	fccw_datapath #(
		.TABLE_BYTES (TABLE_BYTES),
		.MAX_CHAIN   (MAX_CHAIN)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.table_addr    (s_tdata[12:0]),
		.table_byte    (s_tdata[20:13]),
		.start_cluster (s_tdata[32:21]),
		.cfg_valid     (cfg_valid),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.m_tvalid      (m_tvalid),
		.m_tready      (m_tready),
		.out_cluster   (out_cluster),
		.out_sector    (out_sector),
		.out_last      (m_tlast),
		.out_status    (out_status)
	);

	// Result beat packing: cluster in the low bits, sector address above it.
	assign m_tdata = {out_sector, out_cluster};
	assign m_tuser = out_status;

endmodule
